// File: rtl/core/assert_macros.svh
// assertion macros shared by the capture rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define NSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define NSC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/nsc_pkg.sv
// shared types and constants of the sentence capture block
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [7:0] MATCH_A_RST = 8'h4D;
    localparam logic [7:0] MATCH_B_RST = 8'h43;

    localparam int               CFG_IDX_W   = 1;
    localparam [CFG_IDX_W-1:0]   CFG_MATCH_A = 1'b0;
    localparam [CFG_IDX_W-1:0]   CFG_MATCH_B = 1'b1;

    // command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    // result queue on the output side
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_APPEND   = 2'd0,
        CMD_CLEAR    = 2'd1,
        CMD_LINE_END = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/nmea_sentence_capture.sv
// top level of the nmea sentence capture block
`timescale 1ns / 1ps
`default_nettype none

// Captures one sentence type from a raw received byte stream. Each request on
// the push side is one byte; '$' restarts the line, CR is dropped, LF checks
// stored positions 3 and 4 against the two match registers (reset 'M','C')
// and, on a match, delivers the stored bytes in order followed by a zero byte
// with o_is_last set. A byte goes through a two-entry command queue to the
// back end, taken whenever it is idle; during readout it takes no commands.
// The line store, a single-port-read ram with registered read data, is read
// one byte per cycle while the result queue has room, then the terminator is
// queued. Results wait in a four-entry queue, so pop stalls only hold the
// readout, never a byte already queued. The user must write match registers
// through i_cfg_we/i_cfg_idx/i_cfg_data while idle, not enforced by the block.
module nmea_sentence_capture (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [nsc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [7:0]                      i_cfg_data,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [7:0]                      i_rx_byte,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [7:0]                           o_out_byte,
    output logic                                 o_is_last
);

    import nsc_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;

    nsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_rx_byte   (i_rx_byte),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    nsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte),
        .o_is_last   (o_is_last)
    );

endmodule

`default_nettype wire

// File: rtl/core/nsc_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module nsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/nsc_front.sv
// front end: takes received bytes, classifies them and queues commands
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nsc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_cmd_valid,
    output nsc_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_take
);

    import nsc_pkg::*;

    t_cmd             r_slot [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr;
    logic [CQ_AW-1:0] r_rd;
    logic [CQ_CW-1:0] r_cnt;
    logic [CQ_AW-1:0] n_wr;
    logic [CQ_AW-1:0] n_rd;
    logic [CQ_CW-1:0] n_cnt;

    logic accept;
    logic enq;
    logic deq;
    t_cmd cmd_in;

    assign full   = (r_cnt == CQ_CW'(CQ_DEPTH));
    assign accept = push && !full;

    always_comb begin
        cmd_in.data = i_rx_byte;
        priority if (i_rx_byte == CH_DOLLAR) begin
            cmd_in.kind = CMD_CLEAR;
        end else if (i_rx_byte == CH_LF) begin
            cmd_in.kind = CMD_LINE_END;
        end else begin
            cmd_in.kind = CMD_APPEND;
        end
    end

    // carriage return is taken and dropped here
    assign enq = accept && (i_rx_byte != CH_CR);
    assign deq = i_cmd_take && (r_cnt != '0);

    always_comb begin
        n_wr  = enq ? r_wr + 1'b1 : r_wr;
        n_rd  = deq ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + CQ_CW'(enq) - CQ_CW'(deq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_slot[r_wr] <= cmd_in;
        end
    end

    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_slot[r_rd];

    `NSC_ASSERT(a_cq_bound, r_cnt <= CQ_CW'(CQ_DEPTH), "command queue overfilled")
    `NSC_ASSERT_IMPL(a_cq_take, i_cmd_take, r_cnt != '0, "command taken from empty queue")

endmodule

`default_nettype wire

// File: rtl/core/nsc_back.sv
// back end: line store, fill count, match check and sentence readout
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nsc_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [nsc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [7:0]                      i_cfg_data,
    input  wire logic                            i_cmd_valid,
    input  wire nsc_pkg::t_cmd                   i_cmd,
    output logic                                 o_cmd_take,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [7:0]                           o_out_byte,
    output logic                                 o_is_last
);

    import nsc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;
    localparam logic [1:0] ST_TERM = 2'd2;

    localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(LINE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] POS_A    = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] POS_B    = ADDR_W'(4);

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [ADDR_W-1:0] r_fill;
    logic [ADDR_W-1:0] n_fill;
    logic [ADDR_W-1:0] r_k;
    logic [ADDR_W-1:0] n_k;
    logic [7:0]        r_pos_a;
    logic [7:0]        n_pos_a;
    logic [7:0]        r_pos_b;
    logic [7:0]        n_pos_b;
    logic [7:0]        r_match_a;
    logic [7:0]        r_match_b;
    logic              r_inflight;

    t_result           r_q [OQ_DEPTH];
    logic [OQ_AW-1:0]  r_q_wr;
    logic [OQ_AW-1:0]  r_q_rd;
    logic [OQ_CW-1:0]  r_q_cnt;

    logic              take;
    logic              store_we;
    logic              is_match;
    logic              room;
    logic              issue;
    logic              push_term;
    logic              q_push;
    logic              q_pop;
    logic [7:0]        rdata;
    t_result           q_in;

    nsc_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_fill),
        .i_wdata (i_cmd.data),
        .i_raddr (r_k),
        .o_rdata (rdata)
    );

    // positions 3 and 4 are shadowed in flops for the match check
    assign is_match   = (r_pos_a == r_match_a) && (r_pos_b == r_match_b);
    assign take       = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_cmd_take = take;
    assign store_we   = take && (i_cmd.kind == CMD_APPEND) && (r_fill < FILL_MAX);

    // credit: queued results plus the read in flight
    assign room      = (r_q_cnt + OQ_CW'(r_inflight)) < OQ_CW'(OQ_DEPTH);
    assign issue     = (r_state == ST_EMIT) && room;
    assign push_term = (r_state == ST_TERM) && !r_inflight && room;
    assign q_push    = r_inflight || push_term;
    assign q_pop     = pop && (r_q_cnt != '0);

    always_comb begin
        if (r_inflight) begin
            q_in.data = rdata;
            q_in.last = 1'b0;
        end else begin
            q_in.data = CH_NUL;
            q_in.last = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_k     = r_k;
        n_pos_a = r_pos_a;
        n_pos_b = r_pos_b;
        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    unique case (i_cmd.kind)
                        CMD_APPEND: begin
                            if (store_we) begin
                                n_fill = r_fill + 1'b1;
                                if (r_fill == POS_A) begin
                                    n_pos_a = i_cmd.data;
                                end
                                if (r_fill == POS_B) begin
                                    n_pos_b = i_cmd.data;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            n_fill = '0;
                        end
                        CMD_LINE_END: begin
                            if (is_match) begin
                                n_k     = '0;
                                n_state = (r_fill == '0) ? ST_TERM : ST_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (issue) begin
                    if (r_k == r_fill - 1'b1) begin
                        n_state = ST_TERM;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            ST_TERM: begin
                if (push_term) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fill     <= '0;
            r_pos_a    <= '0;
            r_pos_b    <= '0;
            r_inflight <= 1'b0;
            r_match_a  <= MATCH_A_RST;
            r_match_b  <= MATCH_B_RST;
            r_q_wr     <= '0;
            r_q_rd     <= '0;
            r_q_cnt    <= '0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_pos_a    <= n_pos_a;
            r_pos_b    <= n_pos_b;
            r_inflight <= issue;
            if (i_cfg_we && (i_cfg_idx == CFG_MATCH_A)) begin
                r_match_a <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_MATCH_B)) begin
                r_match_b <= i_cfg_data;
            end
            if (q_push) begin
                r_q_wr <= r_q_wr + 1'b1;
            end
            if (q_pop) begin
                r_q_rd <= r_q_rd + 1'b1;
            end
            r_q_cnt <= r_q_cnt + OQ_CW'(q_push) - OQ_CW'(q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        if (q_push) begin
            r_q[r_q_wr] <= q_in;
        end
    end

    assign empty      = (r_q_cnt == '0);
    assign o_out_byte = r_q[r_q_rd].data;
    assign o_is_last  = r_q[r_q_rd].last;

    `NSC_ASSERT(a_fill_bound, r_fill <= FILL_MAX, "fill count beyond line depth")
    `NSC_ASSERT(a_credit, (r_q_cnt + OQ_CW'(r_inflight)) <= OQ_CW'(OQ_DEPTH), "result queue overrun")
    `NSC_ASSERT_IMPL(a_emit_range, r_state == ST_EMIT, r_k < r_fill, "readout index past fill")

endmodule

`default_nettype wire
